// ----- rtl/tscd_pkg.sv -----
// ----------------------------------------------------------------------------
// tscd_pkg
// Shared types, codes and tables of the four-lane scratchpad CRC decoder.
// ----------------------------------------------------------------------------
package tscd_pkg;

  // lanes and storage defaults
  localparam int LANES                = 4;
  localparam int LANE_W               = 2;
  localparam int SCRATCHPAD_BYTES_DEF = 9;
  localparam int QUEUE_DEPTH_DEF      = 2;

  // configuration register indexes
  localparam int           CFG_INDEX_W  = 2;
  localparam logic [1:0]   CFG_SEED     = 2'd0;
  localparam logic [1:0]   CFG_FEEDBACK = 2'd1;

  // configuration reset values
  localparam logic [7:0] SEED_RST     = 8'h00;
  localparam logic [7:0] FEEDBACK_RST = 8'h18;

  // byte classes decided by the front
  localparam logic [1:0] KIND_FIRST  = 2'd0;
  localparam logic [1:0] KIND_SECOND = 2'd1;
  localparam logic [1:0] KIND_MID    = 2'd2;
  localparam logic [1:0] KIND_FINAL  = 2'd3;

  typedef logic [1:0] kind_t;

  // one classified word waiting for the back
  typedef struct packed {
    logic [LANES-1:0][7:0] bytes;
    logic [LANES-1:0]      enable;
    kind_t                 kind;
  } entry_t;

  // configuration seen by the back
  typedef struct packed {
    logic [7:0] seed;
    logic [7:0] feedback;
  } cfg_t;

  // back status for checking
  typedef struct packed {
    logic crc_busy;
    logic emitting;
  } back_status_t;

  // fraction nibble times 625 over 1000, rounded down
  function automatic logic [3:0] tenths_of(input logic [3:0] frac);
    logic [3:0] t;
    case (frac)
      4'd0:    t = 4'd0;
      4'd1:    t = 4'd0;
      4'd2:    t = 4'd1;
      4'd3:    t = 4'd1;
      4'd4:    t = 4'd2;
      4'd5:    t = 4'd3;
      4'd6:    t = 4'd3;
      4'd7:    t = 4'd4;
      4'd8:    t = 4'd5;
      4'd9:    t = 4'd5;
      4'd10:   t = 4'd6;
      4'd11:   t = 4'd6;
      4'd12:   t = 4'd7;
      4'd13:   t = 4'd8;
      4'd14:   t = 4'd8;
      default: t = 4'd9;
    endcase
    return t;
  endfunction

endpackage

// ----- rtl/tscd_front.sv -----
// ----------------------------------------------------------------------------
// tscd_front
// Accepts input words, tracks the scratchpad byte position and tags each
// word with its class before it enters the queue.
// ----------------------------------------------------------------------------
module tscd_front
  import tscd_pkg::*;
#(
  parameter int SCRATCHPAD_BYTES = SCRATCHPAD_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_lane0_byte,
  input  logic [7:0] in_lane1_byte,
  input  logic [7:0] in_lane2_byte,
  input  logic [7:0] in_lane3_byte,
  input  logic [3:0] in_lane_enable,
  input  logic       q_full,
  output logic       in_stall,
  output logic       q_push,
  output entry_t     q_wdata
);

  localparam int             POS_W    = $clog2(SCRATCHPAD_BYTES);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(SCRATCHPAD_BYTES - 1);

  logic [POS_W-1:0] pos_r, pos_nxt;
  kind_t            kind;

  // stall only while the queue has no room
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // classify by position
  always_comb begin
    if (pos_r >= LAST_POS) begin
      kind = KIND_FINAL;
    end else if (pos_r == '0) begin
      kind = KIND_FIRST;
    end else if (pos_r == POS_W'(1)) begin
      kind = KIND_SECOND;
    end else begin
      kind = KIND_MID;
    end
  end

  assign q_wdata.bytes  = {in_lane3_byte, in_lane2_byte, in_lane1_byte, in_lane0_byte};
  assign q_wdata.enable = in_lane_enable;
  assign q_wdata.kind   = kind;

  // position advances per accepted word, wraps after the final byte
  always_comb begin
    pos_nxt = pos_r;
    if (q_push) begin
      if (kind == KIND_FINAL) begin
        pos_nxt = '0;
      end else begin
        pos_nxt = pos_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

// ----- rtl/tscd_queue.sv -----
// ----------------------------------------------------------------------------
// tscd_queue
// Short first-in first-out queue of classified words between front and back.
// ----------------------------------------------------------------------------
module tscd_queue
  import tscd_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t wdata,
  input  logic   pop,
  output entry_t rdata,
  output logic   full,
  output logic   empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t           mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ----- rtl/tscd_back.sv -----
// ----------------------------------------------------------------------------
// tscd_back
// Runs the bit-serial CRC of all four lanes, keeps the temperature bytes and
// emits one decoded reading per enabled lane on the final byte.
// ----------------------------------------------------------------------------
module tscd_back
  import tscd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  cfg_t         cfg,
  input  entry_t       q_rdata,
  input  logic         q_empty,
  output logic         q_pop,
  output back_status_t status,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [1:0]   out_sensor_index,
  output logic         out_crc_error,
  output logic         out_negative,
  output logic [6:0]   out_whole_degrees,
  output logic [3:0]   out_tenths,
  output logic         out_last
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CRC  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [2:0]            bit_cnt_r, bit_cnt_nxt;
  logic [LANES-1:0][7:0] crc_r, crc_nxt;
  logic [LANES-1:0][7:0] data_r, data_nxt;
  logic [LANES-1:0]      mask_r, mask_nxt;
  logic [7:0]            temp_low_r  [LANES];
  logic [7:0]            temp_high_r [LANES];
  logic                  wr_low, wr_high;

  logic                  out_valid_r, out_valid_nxt;
  logic [1:0]            sensor_r;
  logic                  crc_err_r, neg_r, last_r;
  logic [6:0]            whole_r;
  logic [3:0]            tenths_r;

  logic                  slot_free, load;
  logic [LANE_W-1:0]     lane;
  logic [15:0]           raw, mag;
  logic [7:0]            start;

  // one CRC bit, reflected form
  function automatic logic [7:0] crc_bit(input logic [7:0] crc, input logic din,
                                         input logic [7:0] fbk);
    logic       fb;
    logic [7:0] c;
    fb = crc[0] ^ din;
    c  = fb ? (crc ^ fbk) : crc;
    return {fb, c[7:1]};
  endfunction

  // lowest pending lane
  function automatic logic [LANE_W-1:0] lowest(input logic [LANES-1:0] m);
    logic [LANE_W-1:0] idx;
    idx = '0;
    for (int n = LANES - 1; n >= 0; n--) begin
      if (m[n]) begin
        idx = LANE_W'(n);
      end
    end
    return idx;
  endfunction

  assign slot_free = !out_valid_r || !out_stall;
  assign lane      = lowest(mask_r);

  // decode of the selected lane
  assign raw = {temp_high_r[lane], temp_low_r[lane]};
  assign mag = raw[15] ? (~raw + 16'd1) : raw;

  assign status.crc_busy = (state_r == ST_CRC);
  assign status.emitting = (state_r == ST_EMIT);

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    bit_cnt_nxt = bit_cnt_r;
    crc_nxt     = crc_r;
    data_nxt    = data_r;
    mask_nxt    = mask_r;
    q_pop       = 1'b0;
    wr_low      = 1'b0;
    wr_high     = 1'b0;
    load        = 1'b0;
    start       = 8'h00;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          if (q_rdata.kind == KIND_FINAL) begin
            if (q_rdata.enable == '0) begin
              q_pop = 1'b1;
            end else begin
              mask_nxt  = q_rdata.enable;
              state_nxt = ST_EMIT;
            end
          end else begin
            // first bit taken while the word is popped
            q_pop   = 1'b1;
            wr_low  = (q_rdata.kind == KIND_FIRST);
            wr_high = (q_rdata.kind == KIND_SECOND);
            for (int n = 0; n < LANES; n++) begin
              start       = (q_rdata.kind == KIND_FIRST) ? cfg.seed : crc_r[n];
              crc_nxt[n]  = crc_bit(start, q_rdata.bytes[n][0], cfg.feedback);
              data_nxt[n] = {1'b0, q_rdata.bytes[n][7:1]};
            end
            bit_cnt_nxt = 3'd1;
            state_nxt   = ST_CRC;
          end
        end
      end
      ST_CRC: begin
        for (int n = 0; n < LANES; n++) begin
          crc_nxt[n]  = crc_bit(crc_r[n], data_r[n][0], cfg.feedback);
          data_nxt[n] = {1'b0, data_r[n][7:1]};
        end
        bit_cnt_nxt = bit_cnt_r + 3'd1;
        if (bit_cnt_r == 3'd7) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          load     = 1'b1;
          mask_nxt = mask_r & ~(LANES'(1) << lane);
          if (mask_nxt == '0) begin
            q_pop     = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bit_cnt_r   <= '0;
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // crc, shift data and temperature bytes
  always_ff @(posedge clk) begin
    crc_r  <= crc_nxt;
    data_r <= data_nxt;
    for (int n = 0; n < LANES; n++) begin
      if (wr_low) begin
        temp_low_r[n] <= q_rdata.bytes[n];
      end
      if (wr_high) begin
        temp_high_r[n] <= q_rdata.bytes[n];
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      sensor_r  <= 2'(lane);
      crc_err_r <= (crc_r[lane] != q_rdata.bytes[lane]);
      neg_r     <= raw[15];
      whole_r   <= mag[10:4];
      tenths_r  <= tenths_of(mag[3:0]);
      last_r    <= (mask_nxt == '0);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_sensor_index  = sensor_r;
  assign out_crc_error     = crc_err_r;
  assign out_negative      = neg_r;
  assign out_whole_degrees = whole_r;
  assign out_tenths        = tenths_r;
  assign out_last          = last_r;

endmodule

// ----- rtl/temp_scratchpad_crc_decoder.sv -----
// ----------------------------------------------------------------------------
// temp_scratchpad_crc_decoder
// Four-lane scratchpad CRC-8 check and temperature decode, front and back
// parted by a short queue.
// ----------------------------------------------------------------------------
// non-final byte: one CRC bit per cycle on all lanes in the back
// final byte: one reading per enabled lane through the output register, held
//   under out_stall, first via the EMIT state; no lane: popped straight from IDLE
// input taken every cycle while the queue has room; no new word until the CRC ends
// reset: synchronous, active low; clears position, queue, sequencer, output
//   valid and restores crc_seed 0x00 and crc_feedback 0x18; no clearing pass
// ----------------------------------------------------------------------------
module temp_scratchpad_crc_decoder
  import tscd_pkg::*;
#(
  parameter int SCRATCHPAD_BYTES = SCRATCHPAD_BYTES_DEF,
  parameter int QUEUE_DEPTH      = QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             in_lane0_byte,
  input  logic [7:0]             in_lane1_byte,
  input  logic [7:0]             in_lane2_byte,
  input  logic [7:0]             in_lane3_byte,
  input  logic [3:0]             in_lane_enable,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             out_sensor_index,
  output logic                   out_crc_error,
  output logic                   out_negative,
  output logic [6:0]             out_whole_degrees,
  output logic [3:0]             out_tenths,
  output logic                   out_last,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]             cfg_data
);

  logic         q_push, q_pop, q_full, q_empty;
  entry_t       q_wdata, q_rdata;
  cfg_t         cfg;
  back_status_t bstat;
  logic [7:0]   seed_r, feedback_r;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r     <= SEED_RST;
      feedback_r <= FEEDBACK_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_SEED) begin
        seed_r <= cfg_data;
      end else if (cfg_index == CFG_FEEDBACK) begin
        feedback_r <= cfg_data;
      end
    end
  end

  assign cfg.seed     = seed_r;
  assign cfg.feedback = feedback_r;

  tscd_front #(
    .SCRATCHPAD_BYTES(SCRATCHPAD_BYTES)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_lane0_byte (in_lane0_byte),
    .in_lane1_byte (in_lane1_byte),
    .in_lane2_byte (in_lane2_byte),
    .in_lane3_byte (in_lane3_byte),
    .in_lane_enable(in_lane_enable),
    .q_full        (q_full),
    .in_stall      (in_stall),
    .q_push        (q_push),
    .q_wdata       (q_wdata)
  );

  tscd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata(q_wdata),
    .pop  (q_pop),
    .rdata(q_rdata),
    .full (q_full),
    .empty(q_empty)
  );

  tscd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .q_rdata          (q_rdata),
    .q_empty          (q_empty),
    .q_pop            (q_pop),
    .status           (bstat),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sensor_index (out_sensor_index),
    .out_crc_error    (out_crc_error),
    .out_negative     (out_negative),
    .out_whole_degrees(out_whole_degrees),
    .out_tenths       (out_tenths),
    .out_last         (out_last)
  );

`ifndef NO_ASSERTIONS
  // back never pops an empty queue
  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

  // a new reading only appears out of the emit phase
  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(bstat.emitting))
    else $error("reading loaded outside emit phase");

  // crc engine and emitter never run together
  a_back_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({bstat.crc_busy, bstat.emitting}))
    else $error("crc and emit active at once");
`endif

endmodule
